// ===== design/csem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csem_pkg;

  // Sizing
  localparam int THREADS   = 16;
  localparam int COUNT_MAX = 255;
  localparam int COUNT_W   = $clog2(COUNT_MAX + 1);

  // Port field widths
  localparam int MODE_W  = 2;
  localparam int TID_W   = 4;
  localparam int CFG_W   = 8;
  localparam int COUNT_OUT_W = 8;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_TRY    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIGNAL = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;   // reload count, clear waiters
    logic step;   // execute the accepted beat
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_waiter;  // waiter mask non-empty
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/csem_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface csem_req_if;
  logic                       valid;
  logic                       ready;
  logic [csem_pkg::MODE_W-1:0] mode;
  logic [csem_pkg::TID_W-1:0]  thread_id;

  modport source (output valid, output mode, output thread_id, input ready);
  modport sink   (input valid, input mode, input thread_id, output ready);
endinterface

interface csem_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            granted;
  logic                            blocked;
  logic                            woke_valid;
  logic [csem_pkg::TID_W-1:0]       woke_thread;
  logic [csem_pkg::COUNT_OUT_W-1:0] count_after;

  modport source (output valid, output granted, output blocked, output woke_valid,
                  output woke_thread, output count_after, input ready);
  modport sink   (input valid, input granted, input blocked, input woke_valid,
                  input woke_thread, input count_after, output ready);
endinterface

`default_nettype wire

// ===== design/csem_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csem_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  input  wire csem_pkg::dp_stat_t stat,
  output csem_pkg::dp_cmd_t       cmd
);

  localparam logic ST_EMPTY = 1'b0;  // result register free
  localparam logic ST_FULL  = 1'b1;  // result waiting for the sink

  logic state;
  logic state_next;
  logic accept;

  // Take a new beat whenever the result register is free or drains this cycle.
  assign req_ready = (state == ST_EMPTY) || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign rsp_valid = (state == ST_FULL);

  always_comb begin
    cmd.load = cfg_wr_en;
    cmd.step = accept && !cfg_wr_en;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (cmd.step) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (rsp_ready && !cmd.step) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Waiter presence is informational only; it does not gate the handshake.
  logic unused_stat;
  assign unused_stat = stat.has_waiter;

endmodule

`default_nettype wire

// ===== design/csem_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csem_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire csem_pkg::dp_cmd_t                cmd,
  output csem_pkg::dp_stat_t                    stat,
  input  wire logic [csem_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic [csem_pkg::MODE_W-1:0]      mode,
  input  wire logic [csem_pkg::TID_W-1:0]       thread_id,
  output logic                                  granted,
  output logic                                  blocked,
  output logic                                  woke_valid,
  output logic [csem_pkg::TID_W-1:0]            woke_thread,
  output logic [csem_pkg::COUNT_OUT_W-1:0]      count_after
);

  localparam int NT = csem_pkg::THREADS;
  localparam int CW = csem_pkg::COUNT_W;
  localparam logic [CW-1:0] CMAX = CW'(csem_pkg::COUNT_MAX);

  logic [CW-1:0] sem_count;
  logic [CW-1:0] sem_count_next;
  logic [NT-1:0] waiter_mask;
  logic [NT-1:0] waiter_mask_next;
  logic [CW-1:0] load_val;

  logic [NT-1:0] lowest;
  logic [csem_pkg::TID_W-1:0] low_idx;
  logic [NT-1:0] tid_bit;
  logic          tid_ok;
  logic          cnt_pos;
  logic          g_n, b_n, w_n;

  assign stat.has_waiter = |waiter_mask;

  assign load_val = (32'(cfg_data) > csem_pkg::COUNT_MAX) ? CMAX : CW'(cfg_data);

  // Isolate lowest set bit, then encode it.
  assign lowest = waiter_mask & (~waiter_mask + NT'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < NT; i++) begin
      if (lowest[i]) low_idx = low_idx | csem_pkg::TID_W'(i);
    end
  end

  assign tid_ok  = (32'(thread_id) < NT);
  assign tid_bit = tid_ok ? (NT'(1) << thread_id) : '0;
  assign cnt_pos = (sem_count != '0);

  always_comb begin
    sem_count_next   = sem_count;
    waiter_mask_next = waiter_mask;
    g_n = 1'b0;
    b_n = 1'b0;
    w_n = 1'b0;
    unique case (mode)
      csem_pkg::MODE_TRY, csem_pkg::MODE_WAIT: begin
        if (cnt_pos) begin
          sem_count_next = sem_count - CW'(1);
          g_n = 1'b1;
        end else if (mode == csem_pkg::MODE_WAIT && tid_ok) begin
          waiter_mask_next = waiter_mask | tid_bit;
          b_n = 1'b1;
        end
      end
      csem_pkg::MODE_SIGNAL: begin
        waiter_mask_next = waiter_mask & ~lowest;
        w_n = |waiter_mask;
        if (sem_count < CMAX) sem_count_next = sem_count + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sem_count   <= '0;
      waiter_mask <= '0;
    end else if (cmd.load) begin
      sem_count   <= load_val;
      waiter_mask <= '0;
    end else if (cmd.step) begin
      sem_count   <= sem_count_next;
      waiter_mask <= waiter_mask_next;
    end
  end

  // Result register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      granted     <= g_n;
      blocked     <= b_n;
      woke_valid  <= w_n;
      woke_thread <= w_n ? low_idx : '0;
      count_after <= csem_pkg::COUNT_OUT_W'(sem_count_next);
    end
  end

endmodule

`default_nettype wire

// ===== design/counting_semaphore_waiter_mask.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Counting semaphore with a per-thread waiter mask. Each request beat carries
// a mode (try, wait, signal) and a thread id and yields exactly one response
// beat with granted/blocked/woke flags, the woken thread and the count after
// the operation. A beat passes through the count/mask update and lands in a
// single result register; a new beat is accepted every cycle as long as the
// sink drains responses, so sustained throughput is one beat per clock. The
// result register is the only buffer: while it holds an untaken response, a
// new request is accepted only in the cycle the response is taken. Writing
// cfg_wr_data reloads the count (clamped to the maximum) and clears all
// waiters; after reset the count is zero. Writes are expected only while
// the block is idle.

module counting_semaphore_waiter_mask (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [csem_pkg::CFG_W-1:0] cfg_wr_data,
  csem_req_if.sink                        req,
  csem_rsp_if.source                      rsp
);

  csem_pkg::dp_cmd_t  cmd;
  csem_pkg::dp_stat_t stat;

  // Handshake and result-register occupancy.
  csem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Count, waiter mask, find-first waiter and the result register.
  csem_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_data    (cfg_wr_data),
    .mode        (req.mode),
    .thread_id   (req.thread_id),
    .granted     (rsp.granted),
    .blocked     (rsp.blocked),
    .woke_valid  (rsp.woke_valid),
    .woke_thread (rsp.woke_thread),
    .count_after (rsp.count_after)
  );

endmodule

`default_nettype wire

// ===== design/csem_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csem_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cfg_wr_en,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       granted,
  input wire logic       blocked,
  input wire logic       woke_valid,
  input wire logic [3:0] woke_thread,
  input wire logic [7:0] count_after
);

  // Accepted request shows up as a response on the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !cfg_wr_en) |=> rsp_valid)
    else $error("response missing after accepted request");

  // Stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(granted) && $stable(blocked)
      && $stable(woke_valid) && $stable(woke_thread) && $stable(count_after)))
    else $error("stalled response changed");

  // Single result register: no intake while a response is stuck.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !req_ready)
    else $error("request accepted over a stalled response");

  // At most one outcome flag per response.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ($countones({granted, blocked, woke_valid}) <= 1))
    else $error("conflicting outcome flags");

  // A blocked wait only happens with the count at zero.
  a_blocked_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && blocked) |-> (count_after == 8'd0))
    else $error("blocked with units available");

endmodule

bind counting_semaphore_waiter_mask csem_checker u_csem_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_wr_en   (cfg_wr_en),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .granted     (rsp.granted),
  .blocked     (rsp.blocked),
  .woke_valid  (rsp.woke_valid),
  .woke_thread (rsp.woke_thread),
  .count_after (rsp.count_after)
);

`default_nettype wire

// ===== tb/counting_semaphore_waiter_mask_tb.sv =====
`timescale 1ns / 1ps

module counting_semaphore_waiter_mask_tb;

  // Mode 3 is unused by the block: it must act as a no-op.
  localparam logic [csem_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

  // Generous cycle cap: ~2000 beats, each with a worst-case random send gap
  // plus a response stall, and idle pauses around the register writes.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          NUM_PHASES  = 8;
  localparam int          PHASE_BEATS = 244;

  typedef struct packed {
    logic                             granted;
    logic                             blocked;
    logic                             woke_valid;
    logic [csem_pkg::TID_W-1:0]       woke_thread;
    logic [csem_pkg::COUNT_OUT_W-1:0] count_after;
  } sem_result_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // One row of the directed table: either a request beat or a register
  // write. When 'pinned' is set, the beat checks against the hand-typed
  // result rather than the one the predictor works out.
  typedef struct packed {
    row_kind_t                   kind;
    logic [csem_pkg::MODE_W-1:0] mode;
    logic [csem_pkg::TID_W-1:0]  tid;
    logic [csem_pkg::CFG_W-1:0]  cfg;
    logic                        pinned;
    sem_result_t                 res;
  } dir_row_t;

  localparam int DIR_LEN = 22;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    // After reset: count 0, no waiters. Try fails quietly.
    '{ROW_BEAT, csem_pkg::MODE_TRY, 4'd0, 8'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd0, 8'd0}},
    // Waits at count 0 block; top thread, bottom thread, a middle one twice.
    '{ROW_BEAT, csem_pkg::MODE_WAIT, 4'd15, 8'd0, 1'b1, '{1'b0, 1'b1, 1'b0, 4'd0, 8'd0}},
    '{ROW_BEAT, csem_pkg::MODE_WAIT, 4'd0, 8'd0, 1'b1, '{1'b0, 1'b1, 1'b0, 4'd0, 8'd0}},
    '{ROW_BEAT, csem_pkg::MODE_WAIT, 4'd6, 8'd0, 1'b0, '0},
    '{ROW_BEAT, csem_pkg::MODE_WAIT, 4'd6, 8'd0, 1'b0, '0},
    // Unused mode: nothing moves.
    '{ROW_BEAT, MODE_NOP, 4'd15, 8'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd0, 8'd0}},
    // Signal wakes the lowest waiter (0); its thread_id is ignored.
    '{ROW_BEAT, csem_pkg::MODE_SIGNAL, 4'd9, 8'd0, 1'b1, '{1'b0, 1'b0, 1'b1, 4'd0, 8'd1}},
    '{ROW_BEAT, csem_pkg::MODE_WAIT, 4'd9, 8'd0, 1'b0, '0},
    '{ROW_BEAT, csem_pkg::MODE_SIGNAL, 4'd0, 8'd0, 1'b0, '0},
    '{ROW_BEAT, csem_pkg::MODE_SIGNAL, 4'd0, 8'd0, 1'b1, '{1'b0, 1'b0, 1'b1, 4'd15, 8'd2}},
    // Signal with nobody waiting: count only.
    '{ROW_BEAT, csem_pkg::MODE_SIGNAL, 4'd0, 8'd0, 1'b0, '0},
    '{ROW_BEAT, csem_pkg::MODE_TRY, 4'd10, 8'd0, 1'b0, '0},
    // Count at maximum: signal saturates.
    '{ROW_CFG, csem_pkg::MODE_TRY, 4'd0, 8'd255, 1'b0, '0},
    '{ROW_BEAT, csem_pkg::MODE_SIGNAL, 4'd0, 8'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd0, 8'd255}},
    '{ROW_BEAT, csem_pkg::MODE_TRY, 4'd15, 8'd0, 1'b1, '{1'b1, 1'b0, 1'b0, 4'd0, 8'd254}},
    '{ROW_BEAT, MODE_NOP, 4'd0, 8'd0, 1'b0, '0},
    // Single unit: first wait wins, second blocks.
    '{ROW_CFG, csem_pkg::MODE_TRY, 4'd0, 8'd1, 1'b0, '0},
    '{ROW_BEAT, csem_pkg::MODE_WAIT, 4'd3, 8'd0, 1'b1, '{1'b1, 1'b0, 1'b0, 4'd0, 8'd0}},
    '{ROW_BEAT, csem_pkg::MODE_WAIT, 4'd12, 8'd0, 1'b0, '0},
    // A write clears the waiter mask: the next signal wakes nobody.
    '{ROW_CFG, csem_pkg::MODE_TRY, 4'd0, 8'd0, 1'b0, '0},
    '{ROW_BEAT, csem_pkg::MODE_SIGNAL, 4'd5, 8'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd0, 8'd1}},
    '{ROW_BEAT, csem_pkg::MODE_WAIT, 4'd1, 8'd0, 1'b0, '0}
  };

  localparam logic [csem_pkg::CFG_W-1:0] PHASE_CFG [NUM_PHASES] =
    '{8'd0, 8'd255, 8'd3, 8'd1, 8'd254, 8'd0, 8'd9, 8'd2};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en;
  logic [csem_pkg::CFG_W-1:0] cfg_wr_data;

  csem_req_if req_bus ();
  csem_rsp_if rsp_bus ();

  counting_semaphore_waiter_mask u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted block state: semaphore count and one blocked bit per thread.
  int                           sem_count   = 0;
  logic [csem_pkg::THREADS-1:0] waiter_mask = '0;

  sem_result_t pending_results[$];
  int          mismatches = 0;

  // Per-beat side band, driven alongside the request so the monitor knows
  // whether this beat carries a hand-typed expectation.
  logic        beat_pinned;
  sem_result_t beat_pin_res;

  // Idle knobs (percent chance of starting an idle burst).
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_stall_left = 0;

  int unsigned cycle_count = 0;

  // Apply one operation to the predicted state and return the response.
  function automatic sem_result_t sem_apply(logic [csem_pkg::MODE_W-1:0] m,
                                            logic [csem_pkg::TID_W-1:0] t);
    sem_result_t r;
    r = '0;
    case (m)
      csem_pkg::MODE_TRY, csem_pkg::MODE_WAIT: begin
        if (sem_count > 0) begin
          sem_count--;
          r.granted = 1'b1;
        end else if (m == csem_pkg::MODE_WAIT && int'(t) < csem_pkg::THREADS) begin
          waiter_mask[t] = 1'b1;
          r.blocked = 1'b1;
        end
      end
      csem_pkg::MODE_SIGNAL: begin
        for (int i = 0; i < csem_pkg::THREADS; i++) begin
          if (waiter_mask[i] && !r.woke_valid) begin
            waiter_mask[i] = 1'b0;
            r.woke_valid   = 1'b1;
            r.woke_thread  = i[csem_pkg::TID_W-1:0];
          end
        end
        if (sem_count < csem_pkg::COUNT_MAX) sem_count++;
      end
      default: ;
    endcase
    r.count_after = sem_count[csem_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic check_result(sem_result_t want, sem_result_t got);
    if (got.granted !== want.granted) begin
      $display("%0t: granted mismatch: expected %0d, actual %0d",
               $time, want.granted, got.granted);
      mismatches++;
    end
    if (got.blocked !== want.blocked) begin
      $display("%0t: blocked mismatch: expected %0d, actual %0d",
               $time, want.blocked, got.blocked);
      mismatches++;
    end
    if (got.woke_valid !== want.woke_valid) begin
      $display("%0t: woke_valid mismatch: expected %0d, actual %0d",
               $time, want.woke_valid, got.woke_valid);
      mismatches++;
    end
    if (got.woke_thread !== want.woke_thread) begin
      $display("%0t: woke_thread mismatch: expected %0d, actual %0d",
               $time, want.woke_thread, got.woke_thread);
      mismatches++;
    end
    if (got.count_after !== want.count_after) begin
      $display("%0t: count_after mismatch: expected %0d, actual %0d",
               $time, want.count_after, got.count_after);
      mismatches++;
    end
  endtask

  // Monitor: responses first (they belong to older beats), then new requests.
  // All reads here see pre-edge values since every driver uses NBAs.
  always @(posedge clk) begin
    sem_result_t predicted;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: response beat with nothing pending: expected none, actual %h",
                   $time, {rsp_bus.granted, rsp_bus.blocked, rsp_bus.woke_valid,
                           rsp_bus.woke_thread, rsp_bus.count_after});
          mismatches++;
        end else begin
          check_result(pending_results.pop_front(),
                       '{rsp_bus.granted, rsp_bus.blocked, rsp_bus.woke_valid,
                         rsp_bus.woke_thread, rsp_bus.count_after});
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        // Predictor always advances so later rows stay in step.
        predicted = sem_apply(req_bus.mode, req_bus.thread_id);
        pending_results.push_back(beat_pinned ? beat_pin_res : predicted);
      end
    end
  end

  // Response side: random stall bursts, otherwise ready.
  always @(posedge clk) begin
    int burst;
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      rsp_bus.ready <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      burst = $urandom_range(17, 1);
      rx_stall_left <= burst - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Drive one request beat, optionally after a random send gap, and hold it
  // until accepted. valid gets a single NBA per step.
  task automatic send_beat(logic [csem_pkg::MODE_W-1:0] m, logic [csem_pkg::TID_W-1:0] t,
                           logic pin, sem_result_t pin_res);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(17, 1);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.mode      <= m;
    req_bus.thread_id <= t;
    beat_pinned       <= pin;
    beat_pin_res      <= pin_res;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Let everything drain, then let the block settle before returning.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk);   // the last accept has been pushed by now
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write only while idle; reload the predicted count and mask.
  task automatic write_initial_count(logic [csem_pkg::CFG_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sem_count   = (int'(v) > csem_pkg::COUNT_MAX) ? csem_pkg::COUNT_MAX : int'(v);
    waiter_mask = '0;
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 10;
      default: return 30;
    endcase
  endfunction

  initial begin
    logic [csem_pkg::MODE_W-1:0] m;
    logic [csem_pkg::TID_W-1:0]  t;
    logic [csem_pkg::CFG_W-1:0]  cfg;
    int                          sig_pct;
    int                          roll;

    req_bus.valid     = 1'b0;
    req_bus.mode      = csem_pkg::MODE_TRY;
    req_bus.thread_id = '0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    beat_pinned       = 1'b0;
    beat_pin_res      = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, back to back with no idling.
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_initial_count(DIR_ROWS[i].cfg);
      end else begin
        send_beat(DIR_ROWS[i].mode, DIR_ROWS[i].tid,
                  DIR_ROWS[i].pinned, DIR_ROWS[i].res);
      end
    end

    // Random phases, each starting from a fresh initial count. High counts
    // get few signals so the count drains and waits start blocking; low
    // counts get more signals so waiters are woken regularly.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cfg = (ph == 6) ? csem_pkg::CFG_W'($urandom_range(255)) : PHASE_CFG[ph];
      write_initial_count(cfg);
      sig_pct = (cfg > 8'd100) ? $urandom_range(15, 5) : $urandom_range(50, 15);
      if (ph == NUM_PHASES - 1) begin
        // final stretch runs flat out on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = pick_idle_pct();
        rx_idle_pct = pick_idle_pct();
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        roll = $urandom_range(99);
        if (roll < 4)                   m = MODE_NOP;
        else if (roll < 4 + sig_pct)    m = csem_pkg::MODE_SIGNAL;
        else if ($urandom_range(9) < 6) m = csem_pkg::MODE_WAIT;
        else                            m = csem_pkg::MODE_TRY;
        t = csem_pkg::TID_W'($urandom_range(csem_pkg::THREADS - 1));
        send_beat(m, t, 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
